[hw/rtl/pmc_pkg.sv]
// Shared types, register codes, constants and saturation helpers for the PID motor controller.
package pmc_pkg;

    localparam int CFG_IDX_W = 4;
    localparam int GAIN_W    = 31;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT  = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_MODE   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = 4'd7;

    localparam logic [GAIN_W-1:0] CURRENT_GAIN_RESET = 31'd65536;

    // Q16.16 angle constants
    localparam logic signed [35:0] DEG180   = 36'sd11796480;
    localparam logic signed [35:0] DEG360   = 36'sd23592960;
    localparam logic [GAIN_W-1:0]  DRIVE100 = 31'd6553600;

    localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32_MIN = -66'sd2147483648;
    localparam logic signed [65:0] S16_MAX = 66'sd32767;
    localparam logic signed [65:0] S16_MIN = -66'sd32768;
    localparam logic signed [65:0] S48_MAX = 66'sd140737488355327;
    localparam logic signed [65:0] S48_MIN = -66'sd140737488355328;

    typedef struct packed {
        logic signed [31:0] reference;
        logic signed [31:0] feedback;
        logic [3:0]         motor_slot;
    } pmc_in_t;

    typedef struct packed {
        logic signed [31:0] drive;
        logic signed [15:0] current_word;
        logic [2:0]         byte_offset;
    } pmc_out_t;

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [GAIN_W-1:0] integ_limit;
        logic [GAIN_W-1:0] drive_limit;
        logic [GAIN_W-1:0] error_limit;
        logic              angle_mode;
        logic [GAIN_W-1:0] current_gain;
    } pmc_cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_ERR,
        OP_MP,
        OP_MD,
        OP_MIA,
        OP_MIB,
        OP_IT,
        OP_DRV,
        OP_MC,
        OP_OUT
    } pmc_op_t;

    typedef struct packed {
        pmc_op_t op;
    } pmc_cmd_t;

    function automatic logic signed [65:0] clamp_sym(input logic signed [65:0] x,
                                                     input logic [GAIN_W-1:0] lim);
        logic signed [65:0] hi;
        logic signed [65:0] lo;
        hi = $signed({35'd0, lim});
        lo = -hi;
        if (x > hi)
            return hi;
        else if (x < lo)
            return lo;
        return x;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [65:0] c;
        c = (x > S32_MAX) ? S32_MAX : ((x < S32_MIN) ? S32_MIN : x);
        return c[31:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [65:0] x);
        logic signed [65:0] c;
        c = (x > S16_MAX) ? S16_MAX : ((x < S16_MIN) ? S16_MIN : x);
        return c[15:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [65:0] x);
        logic signed [65:0] c;
        c = (x > S48_MAX) ? S48_MAX : ((x < S48_MIN) ? S48_MIN : x);
        return c[47:0];
    endfunction

endpackage

[hw/rtl/pmc_cfg.sv]
// Configuration register file for the PID motor controller.
module pmc_cfg
    import pmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output pmc_cfg_t             cfg
);

    pmc_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{prop_gain:    '0,
                         integ_gain:   '0,
                         deriv_gain:   '0,
                         integ_limit:  '0,
                         drive_limit:  '0,
                         error_limit:  '0,
                         angle_mode:   1'b0,
                         current_gain: CURRENT_GAIN_RESET};
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:    cfg_reg.prop_gain    <= cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:   cfg_reg.integ_gain   <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:   cfg_reg.deriv_gain   <= cfg_data[GAIN_W-1:0];
                REG_INTEG_LIMIT:  cfg_reg.integ_limit  <= cfg_data[GAIN_W-1:0];
                REG_DRIVE_LIMIT:  cfg_reg.drive_limit  <= cfg_data[GAIN_W-1:0];
                REG_ERROR_LIMIT:  cfg_reg.error_limit  <= cfg_data[GAIN_W-1:0];
                REG_ANGLE_MODE:   cfg_reg.angle_mode   <= cfg_data[0];
                REG_CURRENT_GAIN: cfg_reg.current_gain <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

endmodule

[hw/rtl/pmc_ctrl.sv]
// Step sequencer and output-valid control for the PID motor controller.
module pmc_ctrl
    import pmc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output pmc_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_MP,
        ST_MD,
        ST_MIA,
        ST_MIB,
        ST_IT,
        ST_DRV,
        ST_MC,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.op     = OP_NONE;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_ERR;
                end
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = ST_MP;
            end
            ST_MP:
            begin
                cmd.op     = OP_MP;
                state_next = ST_MD;
            end
            ST_MD:
            begin
                cmd.op     = OP_MD;
                state_next = ST_MIA;
            end
            ST_MIA:
            begin
                cmd.op     = OP_MIA;
                state_next = ST_MIB;
            end
            ST_MIB:
            begin
                cmd.op     = OP_MIB;
                state_next = ST_IT;
            end
            ST_IT:
            begin
                cmd.op     = OP_IT;
                state_next = ST_DRV;
            end
            ST_DRV:
            begin
                cmd.op     = OP_DRV;
                state_next = ST_MC;
            end
            ST_MC:
            begin
                cmd.op     = OP_MC;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.op == OP_OUT)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[hw/rtl/pmc_datapath.sv]
// PID datapath: angle wrap, error accumulator, shared multiplier, clamps and output register.
module pmc_datapath
    import pmc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  pmc_cmd_t cmd,
    input  pmc_cfg_t cfg,
    input  pmc_in_t  in_data,
    output pmc_out_t out_data
);

    pmc_in_t            in_reg;
    logic signed [33:0] refw_reg;
    logic signed [31:0] err_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] prev_reg;
    logic signed [47:0] sum_reg;
    logic signed [64:0] prod_reg;
    logic signed [31:0] p_reg;
    logic signed [31:0] d_reg;
    logic signed [54:0] ia_reg;
    logic signed [31:0] i_reg;
    logic signed [31:0] drive_reg;
    pmc_out_t           out_reg;

    logic signed [33:0] refw;
    logic signed [35:0] diff0;
    logic signed [35:0] err_raw;
    logic signed [31:0] err_clip;
    logic signed [65:0] sum_new;
    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] mul_p;
    logic               mul_en;
    logic signed [65:0] integ_q;
    logic signed [33:0] pid_sum;
    logic signed [64:0] cur_rnd;
    logic signed [64:0] cur_q;

    assign out_data = out_reg;

    // negative reference maps up by a full turn in angle mode
    assign refw = (cfg.angle_mode && in_data.reference[31])
                  ? 34'(in_data.reference) + 34'(DEG360)
                  : 34'(in_data.reference);

    // feedback wrap folded into the error: ref - (fdb -+ 360) = diff0 +- 360
    always_comb
    begin
        diff0 = 36'(refw_reg) - 36'(in_reg.feedback);
        if (cfg.angle_mode && (diff0 < -DEG180))
            err_raw = diff0 + DEG360;
        else if (cfg.angle_mode && (diff0 > DEG180))
            err_raw = diff0 - DEG360;
        else
            err_raw = diff0;
    end

    assign err_clip = 32'(clamp_sym(66'(err_reg), cfg.error_limit));
    assign sum_new  = 66'(sum_reg) + 66'(err_clip);

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_MP:
            begin
                mul_a = 33'(err_reg);
                mul_b = $signed({1'b0, cfg.prop_gain});
            end
            OP_MD:
            begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, cfg.deriv_gain});
            end
            OP_MIA:
            begin
                mul_a = 33'($signed(sum_reg[47:24]));
                mul_b = $signed({1'b0, cfg.integ_gain});
            end
            OP_MIB:
            begin
                mul_a = $signed({9'd0, sum_reg[23:0]});
                mul_b = $signed({1'b0, cfg.integ_gain});
            end
            OP_MC:
            begin
                mul_a = 33'(drive_reg);
                mul_b = $signed({1'b0, cfg.current_gain});
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign mul_p = 65'(mul_a) * 65'(mul_b);

    // sum*gain = hi*gain*2^24 + lo*gain, so floor(/2^16) splits exactly
    assign integ_q = (66'(ia_reg) <<< 8) + $signed({27'd0, prod_reg[54:16]});

    assign pid_sum = 34'(p_reg) + 34'(i_reg) + 34'(d_reg);

    // truncation toward zero of drive*current_gain / 2^16
    assign cur_rnd = prod_reg[64] ? 65'sd65535 : 65'sd0;
    assign cur_q   = (prod_reg + cur_rnd) >>> 16;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            sum_reg  <= '0;
        end
        else if (cmd.op == OP_MP)
        begin
            prev_reg <= err_reg;
            sum_reg  <= sat48(sum_new);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_p;
        case (cmd.op)
            OP_LOAD:
            begin
                in_reg   <= in_data;
                refw_reg <= refw;
            end
            OP_ERR:
            begin
                err_reg <= sat32(66'(err_raw));
            end
            OP_MP:
            begin
                diff_reg <= 33'(err_reg) - 33'(prev_reg);
            end
            OP_MD:
            begin
                p_reg <= sat32(66'(prod_reg >>> 16));
            end
            OP_MIA:
            begin
                d_reg <= sat32(66'(prod_reg >>> 16));
            end
            OP_MIB:
            begin
                ia_reg <= prod_reg[54:0];
            end
            OP_IT:
            begin
                i_reg <= 32'(clamp_sym(integ_q, cfg.integ_limit));
            end
            OP_DRV:
            begin
                drive_reg <= 32'(clamp_sym(66'(pid_sum), cfg.drive_limit));
            end
            OP_MC:
            begin
                if (cfg.angle_mode)
                    drive_reg <= 32'(clamp_sym(66'(drive_reg), DRIVE100));
            end
            OP_OUT:
            begin
                out_reg.drive <= drive_reg;
                if (cfg.angle_mode)
                begin
                    out_reg.current_word <= '0;
                    out_reg.byte_offset  <= '0;
                end
                else
                begin
                    out_reg.current_word <= sat16(66'(cur_q));
                    out_reg.byte_offset  <= {in_reg.motor_slot[1:0] + 2'd3, 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[hw/rtl/pid_motor_controller.sv]
// Top level of the PID motor controller: config registers, sequencer and datapath.
//
// Positional PID step in Q16.16. Each input transfer yields one result transfer. An item
// is stepped from its input transfer through the ERR, MP, MD, MIA, MIB, IT, DRV, MC and
// FIN states; its result becomes valid and the input is ready again in the same cycle, so
// no new item starts before the last leaves FIN. The sequencer uses one shared
// 33x32 multiplier that forms, in turn, the P, D, two integral partial products and the
// current scaling. The result sits in an output register, so the next item is taken
// while it waits; a stalled output holds that next item in its final step. Configuration
// writes are always ready and should be made while no item is in flight.
module pid_motor_controller
    import pmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  pmc_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output pmc_out_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    pmc_cfg_t cfg;
    pmc_cmd_t cmd;

    pmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    pmc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule
